[rtl/spr_pkg.sv]
package spr_pkg;

  localparam int BYTE_W     = 8;
  localparam int HOLD_LIMIT = 16;
  localparam int PAT_BITS   = HOLD_LIMIT * BYTE_W;
  localparam int CFG_AW     = 6;
  localparam int CFG_DW     = 64;
  localparam int LEN_W      = 5;

  localparam logic [2:0] REG_PAT_LO  = 3'd0;
  localparam logic [2:0] REG_PAT_HI  = 3'd1;
  localparam logic [2:0] REG_PAT_LEN = 3'd2;
  localparam logic [2:0] REG_REP_LO  = 3'd3;
  localparam logic [2:0] REG_REP_HI  = 3'd4;
  localparam logic [2:0] REG_REP_LEN = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              end_of_text;
    logic              run_last;
  } out_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

[rtl/stream_pattern_replacer_unit.sv]
// Stream find-and-replace. Text enters one byte per request on the in_ channel
// (text_byte, final_byte); results leave on the out_ channel, one byte per
// request, with run_last set on the last result caused by an input byte.
// Bytes that may still begin a match sit in a chain of byte cells; on a
// mismatch the chain shifts out one byte per cycle from the front, while the
// output is not stalled, until the rest is a prefix of the pattern. A full
// match emits the replacement, one byte per cycle unless the output stalls.
// final_byte flushes the chain and adds an end marker (byte_present 0,
// end_of_text 1). An input byte keeps the sequencer through the accept cycle,
// the prefix decision (skipped when the pattern length is zero), its results
// and a closing step that sets run_last. Results pass through a pending
// register to the output register. Pattern and replacement are programmed
// over the APB port (64-bit registers at 8-byte spacing); the user must
// program them only while the unit is idle, which the unit does not enforce.
// A pattern write drops held bytes. A stalled output holds its request and
// the sequencer waits behind it; a new input is taken while the last result
// of the previous one is still waiting.
// Reset (rst_n low, synchronous) clears the configuration and control registers and empties the chain.
module stream_pattern_replacer_unit import spr_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int REPLACE_MAX = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int HOLD_N = (PATTERN_MAX < HOLD_LIMIT) ? PATTERN_MAX : HOLD_LIMIT;
  localparam int REP_N  = (REPLACE_MAX < HOLD_LIMIT) ? REPLACE_MAX : HOLD_LIMIT;
  localparam int CNT_W  = $clog2(HOLD_N+1);
  localparam int REP_W  = $clog2(REP_N+1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PASS  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_REP   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;

  logic [63:0]      pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [LEN_W-1:0] plen_r, rlen_r;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic             pat_wr;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [REP_W-1:0]  rep_idx_r, rep_idx_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              fin_r, fin_nxt;
  out_t              pend_r, out_r, gen, pend_fwd;
  logic              pend_v_r, out_v_r;
  logic              gen_v, close, adv, out_free, load_out;

  logic [CNT_W-1:0]    plen_eff;
  logic [REP_W-1:0]    rlen_eff;
  logic [PAT_BITS-1:0] rep_bits;
  cell_ctl_t           ctl;
  logic [BYTE_W-1:0]   front_byte;
  logic                all_match, prefix_ok;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];
  assign pat_wr     = cfg_wr && (cfg_idx == REG_PAT_LO || cfg_idx == REG_PAT_HI ||
                                 cfg_idx == REG_PAT_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      plen_r   <= '0;
      rep_lo_r <= '0;
      rep_hi_r <= '0;
      rlen_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAT_LO:  pat_lo_r <= cfg_pwdata;
        REG_PAT_HI:  pat_hi_r <= cfg_pwdata;
        REG_PAT_LEN: plen_r   <= cfg_pwdata[LEN_W-1:0];
        REG_REP_LO:  rep_lo_r <= cfg_pwdata;
        REG_REP_HI:  rep_hi_r <= cfg_pwdata;
        REG_REP_LEN: rlen_r   <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAT_LO:  cfg_prdata = pat_lo_r;
      REG_PAT_HI:  cfg_prdata = pat_hi_r;
      REG_PAT_LEN: cfg_prdata = CFG_DW'(plen_r);
      REG_REP_LO:  cfg_prdata = rep_lo_r;
      REG_REP_HI:  cfg_prdata = rep_hi_r;
      REG_REP_LEN: cfg_prdata = CFG_DW'(rlen_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign plen_eff = (plen_r > LEN_W'(HOLD_N)) ? CNT_W'(HOLD_N) : CNT_W'(plen_r);
  assign rlen_eff = (rlen_r > LEN_W'(REP_N)) ? REP_W'(REP_N) : REP_W'(rlen_r);
  assign rep_bits = {rep_hi_r, rep_lo_r};

  spr_chain #(.DEPTH(HOLD_N)) u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .cnt        (cnt_r),
    .wr_byte    (in_data.text_byte),
    .pattern    ({pat_hi_r, pat_lo_r}),
    .front_byte (front_byte),
    .all_match  (all_match)
  );

  assign prefix_ok = all_match && (cnt_r <= plen_eff);
  assign out_free  = !out_v_r || !out_stall;
  assign adv       = !pend_v_r || out_free;
  assign in_stall  = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rep_idx_nxt = rep_idx_r;
    byte_nxt    = byte_r;
    fin_nxt     = fin_r;
    ctl         = '0;
    gen_v       = 1'b0;
    gen         = '0;
    close       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.text_byte;
          fin_nxt  = in_data.final_byte;
          if (plen_eff == '0) begin
            state_nxt = S_PASS;
          end else begin
            ctl.load  = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = S_CHECK;
          end
        end
      end
      S_PASS: begin
        if (adv) begin
          gen_v            = 1'b1;
          gen.byte_present = 1'b1;
          if (cnt_r != '0) begin
            gen.out_byte = front_byte;
            ctl.shift    = 1'b1;
            cnt_nxt      = cnt_r - CNT_W'(1);
          end else begin
            gen.out_byte = byte_r;
            state_nxt    = fin_r ? S_FIN : S_CLOSE;
          end
        end
      end
      S_CHECK: begin
        if (cnt_r != '0 && !prefix_ok) begin
          if (adv) begin
            gen_v            = 1'b1;
            gen.byte_present = 1'b1;
            gen.out_byte     = front_byte;
            ctl.shift        = 1'b1;
            cnt_nxt          = cnt_r - CNT_W'(1);
          end
        end else if (cnt_r == plen_eff) begin
          cnt_nxt     = '0;
          rep_idx_nxt = '0;
          if (rlen_eff != '0) begin
            state_nxt = S_REP;
          end else begin
            state_nxt = fin_r ? S_FIN : S_CLOSE;
          end
        end else begin
          state_nxt = fin_r ? S_FIN : S_CLOSE;
        end
      end
      S_REP: begin
        if (adv) begin
          gen_v            = 1'b1;
          gen.byte_present = 1'b1;
          gen.out_byte     = rep_bits[4'(rep_idx_r)*BYTE_W +: BYTE_W];
          rep_idx_nxt      = rep_idx_r + REP_W'(1);
          if (rep_idx_r == rlen_eff - REP_W'(1)) begin
            state_nxt = fin_r ? S_FIN : S_CLOSE;
          end
        end
      end
      S_FIN: begin
        if (adv) begin
          gen_v = 1'b1;
          if (cnt_r != '0) begin
            gen.byte_present = 1'b1;
            gen.out_byte     = front_byte;
            ctl.shift        = 1'b1;
            cnt_nxt          = cnt_r - CNT_W'(1);
          end else begin
            gen.end_of_text = 1'b1;
            state_nxt       = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          close     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign load_out = (gen_v && pend_v_r) || close;

  always_comb begin
    pend_fwd          = pend_r;
    pend_fwd.run_last = close;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rep_idx_r <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= pat_wr ? '0 : cnt_nxt;
      rep_idx_r <= rep_idx_nxt;
      if (gen_v) begin
        pend_v_r <= 1'b1;
      end else if (close) begin
        pend_v_r <= 1'b0;
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    fin_r  <= fin_nxt;
    if (gen_v) begin
      pend_r <= gen;
    end
    if (load_out) begin
      out_r <= pend_fwd;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pending result left over while idle");

  a_held_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && plen_eff != '0) |-> cnt_r < plen_eff)
    else $error("held bytes reach pattern length while idle");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_text) |-> out_data.run_last)
    else $error("end marker not last of its run");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != S_IDLE)
    else $error("sequencer did not start after accept");

endmodule

[rtl/spr_cell.sv]
module spr_cell import spr_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] nbr_byte,
  input  logic [BYTE_W-1:0] wr_byte,
  input  logic [BYTE_W-1:0] pat_byte,
  output logic [BYTE_W-1:0] held_byte,
  output logic              match
);

  logic [BYTE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= nbr_byte;
    end else if (ctl.load) begin
      data_r <= wr_byte;
    end
  end

  assign held_byte = data_r;
  assign match     = (data_r == pat_byte);

endmodule

[rtl/spr_chain.sv]
module spr_chain import spr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   cnt,
  input  logic [BYTE_W-1:0]            wr_byte,
  input  logic [PAT_BITS-1:0]          pattern,
  output logic [BYTE_W-1:0]            front_byte,
  output logic                         all_match
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [BYTE_W-1:0] held_w [DEPTH+1];
  logic [DEPTH-1:0]  ok_w;

  assign held_w[DEPTH] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_ctl_t cctl;
    logic      m;

    assign cctl.shift = ctl.shift;
    assign cctl.load  = ctl.load && (cnt == CNT_W'(k));

    spr_cell u_cell (
      .clk       (clk),
      .ctl       (cctl),
      .nbr_byte  (held_w[k+1]),
      .wr_byte   (wr_byte),
      .pat_byte  (pattern[k*BYTE_W +: BYTE_W]),
      .held_byte (held_w[k]),
      .match     (m)
    );

    // entries at or above the count are not held
    assign ok_w[k] = m || (CNT_W'(k) >= cnt);
  end

  assign front_byte = held_w[0];
  assign all_match  = &ok_w;

endmodule

[sim/tb_stream_pattern_replacer_unit.sv]
`timescale 1ns / 1ps

module tb_stream_pattern_replacer_unit;
  import spr_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int PATTERN_MAX  = 16;
  localparam int REPLACE_MAX  = 16;
  localparam int SETTLE_CYC   = 16;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RAND_PHASES  = 10;
  localparam int HOLD_PHASE   = 3;
  localparam logic [2:0] REG_SPARE = 3'd6;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  stream_pattern_replacer_unit #(
    .PATTERN_MAX(PATTERN_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mirror of the programmed registers and the held bytes
  logic [63:0] pat_lo = '0, pat_hi = '0, rep_lo = '0, rep_hi = '0;
  logic [4:0]  pat_len = '0, rep_len = '0;
  logic [7:0]  held_text [HOLD_LIMIT];
  int          held_n = 0;

  in_t  pending_text [$];
  out_t expected_text [$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  bit   in_took = 1'b0;
  out_t want;

  // text generation knobs
  bit         small_alpha = 1'b0;
  logic [7:0] alpha [2];

  function automatic logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int k);
    logic [127:0] all;
    all = {hi, lo};
    return all[8*k +: 8];
  endfunction

  function automatic int clamp_len(logic [4:0] len, int cap);
    int v;
    v = int'(len);
    if (v > cap) v = cap;
    if (v > HOLD_LIMIT) v = HOLD_LIMIT;
    return v;
  endfunction

  function automatic out_t text_result(logic [7:0] b);
    out_t r;
    r = '0;
    r.out_byte = b;
    r.byte_present = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] pop_held();
    logic [7:0] front;
    front = held_text[0];
    for (int k = 0; k < HOLD_LIMIT - 1; k++) held_text[k] = held_text[k+1];
    held_n--;
    return front;
  endfunction

  function automatic bit held_matches_prefix(int plen);
    if (held_n > plen) return 1'b0;
    for (int k = 0; k < held_n; k++)
      if (held_text[k] != byte_at(pat_lo, pat_hi, k)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_replace(in_t item);
    out_t run [$];
    out_t marker;
    int   plen;
    int   rlen;
    plen = clamp_len(pat_len, PATTERN_MAX);
    rlen = clamp_len(rep_len, REPLACE_MAX);
    if (plen == 0) begin
      while (held_n > 0) run.push_back(text_result(pop_held()));
      run.push_back(text_result(item.text_byte));
    end else begin
      if (held_n >= HOLD_LIMIT) run.push_back(text_result(pop_held()));
      held_text[held_n] = item.text_byte;
      held_n++;
      while (held_n > 0 && !held_matches_prefix(plen)) run.push_back(text_result(pop_held()));
      if (held_n == plen) begin
        for (int k = 0; k < rlen; k++) run.push_back(text_result(byte_at(rep_lo, rep_hi, k)));
        held_n = 0;
      end
    end
    if (item.final_byte) begin
      while (held_n > 0) run.push_back(text_result(pop_held()));
      marker = '0;
      marker.end_of_text = 1'b1;
      run.push_back(marker);
    end
    if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
    foreach (run[i]) expected_text.push_back(run[i]);
  endfunction

  function automatic void check_field(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
      mismatches++;
    end
  endfunction

  // request acceptance, prediction, result checking and watchdog
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        predict_replace(in_data);
        void'(pending_text.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $display("%0t ns: unexpected result: expected none, got %p", $time, out_data);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("byte_present", 8'(want.byte_present), 8'(out_data.byte_present));
          check_field("end_of_text", 8'(want.end_of_text), 8'(out_data.end_of_text));
          check_field("run_last", 8'(want.run_last), 8'(out_data.run_last));
        end
      end
      if (in_took || (out_valid && !out_stall) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: timeout, %0d results outstanding", $time, expected_text.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_text.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_text[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 2);
            2: gap_left = $urandom_range(3, 10);
            default: gap_left = $urandom_range(0, 1);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own plus a requested long hold-off
  int       hold_requests = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_e rx_mode = RX_FREE;

  always @(negedge clk) begin
    if (hold_served < hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
        default:  out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_PAT_LO: begin
        pat_lo = value;
        held_n = 0;
      end
      REG_PAT_HI: begin
        pat_hi = value;
        held_n = 0;
      end
      REG_PAT_LEN: begin
        pat_len = value[4:0];
        held_n = 0;
      end
      REG_REP_LO: rep_lo = value;
      REG_REP_HI: rep_hi = value;
      REG_REP_LEN: rep_len = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic push_text(logic [7:0] b, logic fin);
    in_t item;
    item.text_byte = b;
    item.final_byte = fin;
    pending_text.push_back(item);
  endtask

  // waits until all queued text is sent and every expected result is back, then lets the unit settle
  task automatic drain();
    while (pending_text.size() != 0 || in_valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    if (small_alpha && $urandom_range(0, 1)) return alpha[$urandom_range(0, 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_setup();
    logic [127:0] pat_bytes;
    logic [4:0]   plen_val;
    logic [4:0]   rlen_val;
    small_alpha = 1'($urandom_range(0, 1));
    alpha[0] = 8'($urandom_range(0, 255));
    alpha[1] = 8'($urandom_range(0, 255));
    for (int k = 0; k < HOLD_LIMIT; k++)
      pat_bytes[8*k +: 8] = small_alpha ? alpha[$urandom_range(0, 1)] :
                                          8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: plen_val = 5'd0;
      1: plen_val = 5'd16;
      2: plen_val = 5'($urandom_range(17, 31));
      default: plen_val = 5'($urandom_range(1, 5));
    endcase
    rlen_val = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) :
                                                $urandom_range(0, 16));
    cfg_write(REG_PAT_LO, pat_bytes[63:0]);
    cfg_write(REG_PAT_HI, pat_bytes[127:64]);
    cfg_write(REG_PAT_LEN, {59'd0, plen_val});
    cfg_write(REG_REP_LO, {$urandom, $urandom});
    cfg_write(REG_REP_HI, {$urandom, $urandom});
    cfg_write(REG_REP_LEN, {59'd0, rlen_val});
  endtask

  // mostly whole or partial copies of the pattern, with noise in between
  task automatic queue_random_text(int count, bit close_text);
    int pushed;
    int seg_len;
    int pick;
    int plen;
    logic [7:0] b;
    pushed = 0;
    plen = clamp_len(pat_len, PATTERN_MAX);
    while (pushed < count) begin
      pick = $urandom_range(0, 9);
      if (plen == 0 || pick >= 8) seg_len = 1;
      else if (pick < 5) seg_len = plen;
      else seg_len = $urandom_range(1, plen);
      for (int k = 0; k < seg_len && pushed < count; k++) begin
        b = (plen == 0 || pick >= 8) ? noise_byte() : byte_at(pat_lo, pat_hi, k);
        pushed++;
        push_text(b, (close_text && pushed == count) || ($urandom_range(0, 40) == 0));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pass-through with the reset configuration
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(8'hA5, 1'b1);
    drain();

    // short pattern, restart after a false start, held byte flushed at the end
    cfg_write(REG_PAT_LO, 64'h6261);
    cfg_write(REG_PAT_LEN, 64'd2);
    cfg_write(REG_REP_LO, 64'h5A5958);
    cfg_write(REG_REP_LEN, 64'd3);
    push_text(8'h61, 1'b0);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b0);
    push_text(8'h63, 1'b0);
    push_text(8'h61, 1'b1);
    drain();

    // lengths above range clamp to the full sixteen bytes
    cfg_write(REG_PAT_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_PAT_HI, 64'h0);
    cfg_write(REG_PAT_LEN, 64'd31);
    cfg_write(REG_REP_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_REP_HI, 64'h0);
    cfg_write(REG_REP_LEN, 64'd20);
    for (int k = 0; k < HOLD_LIMIT; k++) push_text(k < 8 ? 8'hFF : 8'h00, k == HOLD_LIMIT - 1);
    drain();

    // pattern rewritten mid-text drops the held bytes; empty replacement deletes
    cfg_write(REG_PAT_LO, 64'h636261);
    cfg_write(REG_PAT_LEN, 64'd3);
    cfg_write(REG_REP_LEN, 64'd0);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b0);
    drain();
    cfg_write(REG_PAT_LO, 64'h636261);
    cfg_write(REG_SPARE, 64'hDEAD_BEEF_0123_4567);
    push_text(8'h63, 1'b0);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b0);
    push_text(8'h63, 1'b1);
    drain();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      random_setup();
      if (phase == HOLD_PHASE) hold_requests++;
      queue_random_text(phase == HOLD_PHASE ? 50 : $urandom_range(30, 50),
                        $urandom_range(0, 9) < 7);
      drain();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
